// ===== rtl/tpi_pkg.sv =====
// Shared types and constants of the three-plane intersection pipeline.
// Used by every module of the block; depends on nothing.

package tpi_pkg;

  // field widths
  localparam int NORM_W  = 18;   // Q2.16 normal component
  localparam int DIST_W  = 32;   // Q16.16 distance
  localparam int COORD_W = 32;   // Q16.16 result coordinate
  localparam int FRAC_W  = 16;   // fractional bits of the result

  // input beat layout: per plane three normals then the distance
  localparam int PLANE_W     = 3 * NORM_W + DIST_W;
  localparam int IN_FIELDS_W = 3 * PLANE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 3 * COORD_W;
  localparam int OUT_TUSER_W = 2;

  // tuser bit positions on the result side
  localparam int USER_FOUND = 0;
  localparam int USER_OVF   = 1;

  // internal widths
  localparam int PROD_W = 2 * NORM_W;        // product of two normals
  localparam int CF_W   = PROD_W + 1;        // cofactor
  localparam int LO_W   = 18;                // low slice of a cofactor
  localparam int HI_W   = CF_W - LO_W;       // high slice, signed
  localparam int DP_W   = NORM_W + CF_W;     // determinant term
  localparam int PH_W   = HI_W + DIST_W;     // high partial product
  localparam int PL_W   = LO_W + 1 + DIST_W; // low partial product
  localparam int NP_W   = CF_W + DIST_W;     // cofactor times distance
  localparam int DET_W  = 56;                // determinant, signed
  localparam int NUM_W  = 71;                // numerator sum, signed
  localparam int Q_W    = COORD_W + 1;       // quotient bits developed
  localparam int PRE_SH = Q_W - FRAC_W;      // numerator bits below the first step

  typedef logic signed [DET_W-1:0] det_t;
  typedef logic signed [NUM_W-1:0] num_t;

  // front end result: determinant and the three numerators
  typedef struct packed {
    det_t             det;
    logic [2:0][NUM_W-1:0] num;
  } front_t;

  // state of one axis inside the divider
  typedef struct packed {
    logic             neg;
    logic             ovf;
    logic [DET_W-1:0] rem;
    logic [Q_W-1:0]   low;
    logic [Q_W-1:0]   q;
  } axis_t;

  typedef struct packed {
    logic             found;
    logic [DET_W-1:0] den;
    axis_t [2:0]      ax;
  } div_t;

endpackage

// ===== rtl/three_plane_intersection.sv =====
// Top level of the three-plane intersection: front end, divider, output register.
// Depends on tpi_pkg, tpi_front and tpi_div.
//
// Usage: each beat on the s_ channel carries three planes (normal in Q2.16,
// distance in Q16.16). For each beat one result beat leaves on the m_ channel
// with the common point in Q16.16, a found flag and an overflow flag.
// A zero determinant gives found low and all other fields zero; a coordinate
// out of range saturates and sets overflow.
// From acceptance to m_tvalid a beat passes five front-end stages
// (products, cofactors, partial products, determinant and recombination,
// numerator sums), one divider set-up stage, 33 divider steps of one
// quotient bit each, and the output register.
// One beat per cycle while m_tready is high; every stage has its own valid bit.
// When the receiver holds m_tready low, the pipeline keeps filling its empty
// stages and s_tready drops only once every stage is occupied. Nothing is
// lost or repeated across a stall.
// Reset (rst, synchronous) clears all valid bits; the pipeline comes up empty.

module three_plane_intersection (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // plane a nx, ny, nz, distance, then plane b, then plane c, zero pad on top
  input  logic [tpi_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // point_x, point_y, point_z
  output logic [tpi_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // found, overflow
  output logic [tpi_pkg::OUT_TUSER_W-1:0]     m_tuser
);
  import tpi_pkg::*;

  front_t               f_data;
  logic                 f_valid;
  logic                 f_ready;
  div_t                 d_data;
  logic                 d_valid;
  logic                 d_ready;

  logic [COORD_W-1:0]   coord [3];
  logic [2:0]           sat;

  tpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_data  (f_data)
  );

  tpi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  // sign and saturation of each quotient
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      if (d_data.ax[a].neg) begin
        sat[a] = d_data.ax[a].ovf || (d_data.ax[a].q > (Q_W'(1) << (COORD_W-1)));
        coord[a] = sat[a] ? {1'b1, {(COORD_W-1){1'b0}}}
                          : -d_data.ax[a].q[COORD_W-1:0];
      end else begin
        sat[a] = d_data.ax[a].ovf || d_data.ax[a].q[COORD_W] ||
                 d_data.ax[a].q[COORD_W-1];
        coord[a] = sat[a] ? {1'b0, {(COORD_W-1){1'b1}}}
                          : d_data.ax[a].q[COORD_W-1:0];
      end
    end
  end

  // output register
  assign d_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (d_ready) begin
      m_tvalid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      if (d_data.found) begin
        m_tdata            <= {coord[2], coord[1], coord[0]};
        m_tuser[USER_FOUND] <= 1'b1;
        m_tuser[USER_OVF]   <= |sat;
      end else begin
        m_tdata            <= '0;
        m_tuser[USER_FOUND] <= 1'b0;
        m_tuser[USER_OVF]   <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // no intersection means an all-zero result
  a_not_found_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[USER_FOUND] |-> m_tdata == '0 && !m_tuser[USER_OVF])
    else $error("result without intersection is not zero");

  // an overflow flag needs a coordinate pinned at one end of the range
  a_ovf_pinned: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[USER_OVF] |->
      m_tdata[31:0] == 32'h7fffffff || m_tdata[31:0] == 32'h80000000 ||
      m_tdata[63:32] == 32'h7fffffff || m_tdata[63:32] == 32'h80000000 ||
      m_tdata[95:64] == 32'h7fffffff || m_tdata[95:64] == 32'h80000000)
    else $error("overflow without a saturated coordinate");

  // with the output register empty the whole pipeline can advance
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output register empty");
`endif

endmodule

// ===== rtl/tpi_front.sv =====
// Five-stage front end: cofactors, determinant and the three numerators.
// Depends on tpi_pkg.

module tpi_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [tpi_pkg::IN_TDATA_W-1:0]    in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output tpi_pkg::front_t                   out_data
);
  import tpi_pkg::*;

  logic [4:0] v;
  logic [4:0] rdy;

  logic signed [NORM_W-1:0] m [9];
  logic signed [DIST_W-1:0] d_in [3];

  // stage registers
  logic signed [PROD_W-1:0] pa [9];
  logic signed [PROD_W-1:0] pb [9];
  logic signed [NORM_W-1:0] r0m [3];
  logic signed [DIST_W-1:0] d0 [3];
  logic signed [CF_W-1:0]   cf [9];
  logic signed [NORM_W-1:0] r1m [3];
  logic signed [DIST_W-1:0] d1 [3];
  logic signed [DP_W-1:0]   dp [3];
  logic signed [PH_W-1:0]   ph [9];
  logic signed [PL_W-1:0]   pl [9];
  logic signed [DET_W-1:0]  det3;
  logic signed [NP_W-1:0]   np [9];
  logic signed [DET_W-1:0]  det4;
  logic signed [NUM_W-1:0]  num4 [3];

  // per-stage ready: a stage loads when empty or when its successor moves
  always_comb begin
    rdy[4] = !v[4] || out_ready;
    for (int k = 3; k >= 0; k--) begin
      rdy[k] = !v[k] || rdy[k+1];
    end
  end
  assign in_ready = rdy[0];

  // unpack the beat
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) begin
        m[r*3+k] = in_data[r*PLANE_W + k*NORM_W +: NORM_W];
      end
      d_in[r] = in_data[r*PLANE_W + 3*NORM_W +: DIST_W];
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (rdy[0]) v[0] <= in_valid;
      for (int k = 1; k < 5; k++) begin
        if (rdy[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 0: the eighteen products of normal pairs
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pa[0] <= m[4] * m[8];  pb[0] <= m[5] * m[7];
      pa[1] <= m[2] * m[7];  pb[1] <= m[1] * m[8];
      pa[2] <= m[1] * m[5];  pb[2] <= m[2] * m[4];
      pa[3] <= m[5] * m[6];  pb[3] <= m[3] * m[8];
      pa[4] <= m[0] * m[8];  pb[4] <= m[2] * m[6];
      pa[5] <= m[2] * m[3];  pb[5] <= m[0] * m[5];
      pa[6] <= m[3] * m[7];  pb[6] <= m[4] * m[6];
      pa[7] <= m[1] * m[6];  pb[7] <= m[0] * m[7];
      pa[8] <= m[0] * m[4];  pb[8] <= m[1] * m[3];
      for (int k = 0; k < 3; k++) begin
        r0m[k] <= m[k];
        d0[k]  <= d_in[k];
      end
    end
  end

  // stage 1: cofactors
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int i = 0; i < 9; i++) begin
        cf[i] <= CF_W'(pa[i]) - CF_W'(pb[i]);
      end
      for (int k = 0; k < 3; k++) begin
        r1m[k] <= r0m[k];
        d1[k]  <= d0[k];
      end
    end
  end

  // stage 2: determinant terms and split cofactor-distance products
  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      for (int k = 0; k < 3; k++) begin
        dp[k] <= DP_W'(r1m[k]) * DP_W'(cf[3*k]);
      end
      for (int i = 0; i < 9; i++) begin
        ph[i] <= PH_W'($signed(cf[i][CF_W-1:LO_W])) * PH_W'(d1[i%3]);
        pl[i] <= PL_W'($signed({1'b0, cf[i][LO_W-1:0]})) * PL_W'(d1[i%3]);
      end
    end
  end

  // stage 3: determinant and recombined products
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      det3 <= DET_W'(dp[0]) + DET_W'(dp[1]) + DET_W'(dp[2]);
      for (int i = 0; i < 9; i++) begin
        np[i] <= (NP_W'(ph[i]) <<< LO_W) + NP_W'(pl[i]);
      end
    end
  end

  // stage 4: numerator sums per axis
  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      det4 <= det3;
      for (int r = 0; r < 3; r++) begin
        num4[r] <= NUM_W'(np[3*r]) + NUM_W'(np[3*r+1]) + NUM_W'(np[3*r+2]);
      end
    end
  end

  assign out_valid = v[4];
  always_comb begin
    out_data.det = det4;
    for (int r = 0; r < 3; r++) begin
      out_data.num[r] = num4[r];
    end
  end

endmodule

// ===== rtl/tpi_div_step.sv =====
// One registered step of the restoring divider: one quotient bit per axis.
// Depends on tpi_pkg.

module tpi_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tpi_pkg::div_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output tpi_pkg::div_t  out_data
);
  import tpi_pkg::*;

  div_t             nxt;
  logic [DET_W:0]   rem2 [3];
  logic [DET_W:0]   diff [3];

  // trial subtraction for each axis
  always_comb begin
    nxt = in_data;
    for (int a = 0; a < 3; a++) begin
      rem2[a] = {in_data.ax[a].rem, in_data.ax[a].low[Q_W-1]};
      diff[a] = rem2[a] - {1'b0, in_data.den};
      nxt.ax[a].low = {in_data.ax[a].low[Q_W-2:0], 1'b0};
      if (!diff[a][DET_W]) begin
        nxt.ax[a].rem = diff[a][DET_W-1:0];
        nxt.ax[a].q   = {in_data.ax[a].q[Q_W-2:0], 1'b1};
      end else begin
        nxt.ax[a].rem = rem2[a][DET_W-1:0];
        nxt.ax[a].q   = {in_data.ax[a].q[Q_W-2:0], 1'b0};
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) out_data <= nxt;
  end

endmodule

// ===== rtl/tpi_div.sv =====
// Pipelined signed divider: one set-up stage, then one step per quotient bit.
// Depends on tpi_pkg and tpi_div_step.

module tpi_div (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tpi_pkg::front_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tpi_pkg::div_t    out_data
);
  import tpi_pkg::*;

  div_t             prep;
  div_t             prep_q;
  logic             prep_v;
  logic             prep_rdy;
  logic [NUM_W-1:0] mag [3];
  logic [DET_W-1:0] den;

  div_t             sd [Q_W+1];
  logic [Q_W:0]     sv;
  logic [Q_W:0]     sr;

  // set-up: magnitudes, signs and the early range check
  always_comb begin
    den = in_data.det[DET_W-1] ? DET_W'(-in_data.det) : DET_W'(in_data.det);
    prep.found = (in_data.det != '0);
    prep.den   = den;
    for (int a = 0; a < 3; a++) begin
      mag[a] = in_data.num[a][NUM_W-1] ? -in_data.num[a] : in_data.num[a];
      prep.ax[a].neg = in_data.num[a][NUM_W-1] ^ in_data.det[DET_W-1];
      // quotient needs more than Q_W bits
      prep.ax[a].ovf = DET_W'(mag[a][NUM_W-1:PRE_SH]) >= den;
      prep.ax[a].rem = prep.ax[a].ovf ? '0 : DET_W'(mag[a][NUM_W-1:PRE_SH]);
      prep.ax[a].low = {mag[a][PRE_SH-1:0], FRAC_W'(0)};
      prep.ax[a].q   = '0;
    end
  end

  assign prep_rdy = !prep_v || sr[0];
  assign in_ready = prep_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      prep_v <= 1'b0;
    end else if (prep_rdy) begin
      prep_v <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (prep_rdy) prep_q <= prep;
  end

  assign sd[0] = prep_q;
  assign sv[0] = prep_v;

  // one step per quotient bit
  for (genvar j = 0; j < Q_W; j++) begin : g_step
    tpi_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (sv[j]),
      .in_ready  (sr[j]),
      .in_data   (sd[j]),
      .out_valid (sv[j+1]),
      .out_ready (sr[j+1]),
      .out_data  (sd[j+1])
    );
  end

  assign sr[Q_W]   = out_ready;
  assign out_valid = sv[Q_W];
  assign out_data  = sd[Q_W];

endmodule

// ===== tb/tpi_checker.sv =====
`timescale 1ns / 100ps
// Result checker for the three-plane intersection: predicts each result beat
// from the accepted input beat and compares it field by field. Needs tpi_pkg.

module tpi_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [tpi_pkg::IN_TDATA_W-1:0] s_tdata,
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [tpi_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic [tpi_pkg::OUT_TUSER_W-1:0] m_tuser,
  output int                             mismatches,
  output int                             pending,
  output int                             points_seen,
  output int                             misses_seen,
  output int                             clamps_seen
);
  import tpi_pkg::*;

  localparam int EXP_DEPTH = 2048;

  typedef struct packed {
    logic               found;
    logic               overflow;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
  } point_t;

  // expected results in arrival order, circular
  point_t exp_mem [EXP_DEPTH];
  int     wr_cnt = 0;
  int     rd_cnt = 0;

  // solve the 3x3 system exactly, divide truncating toward zero, then clamp
  function automatic point_t solve_point(input logic [IN_TDATA_W-1:0] d);
    logic signed [127:0] m [9];
    logic signed [127:0] dv [3];
    logic signed [127:0] cf [9];
    logic signed [127:0] det, num, quo;
    logic [COORD_W-1:0]  crd [3];
    point_t p;
    p = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++)
        m[r*3+k] = $signed(d[r*PLANE_W + k*NORM_W +: NORM_W]);
      dv[r] = $signed(d[r*PLANE_W + 3*NORM_W +: DIST_W]);
    end
    cf[0] = m[4]*m[8] - m[5]*m[7];
    cf[3] = m[5]*m[6] - m[3]*m[8];
    cf[6] = m[3]*m[7] - m[4]*m[6];
    det = m[0]*cf[0] + m[1]*cf[3] + m[2]*cf[6];
    if (det == 0) return p;
    cf[1] = m[2]*m[7] - m[1]*m[8];
    cf[4] = m[0]*m[8] - m[2]*m[6];
    cf[7] = m[1]*m[6] - m[0]*m[7];
    cf[2] = m[1]*m[5] - m[2]*m[4];
    cf[5] = m[2]*m[3] - m[0]*m[5];
    cf[8] = m[0]*m[4] - m[1]*m[3];
    p.found = 1'b1;
    for (int r = 0; r < 3; r++) begin
      num = (cf[r*3]*dv[0] + cf[r*3+1]*dv[1] + cf[r*3+2]*dv[2]) <<< FRAC_W;
      quo = num / det;
      if (quo > 128'sh7FFFFFFF) begin
        crd[r] = 32'h7FFFFFFF;
        p.overflow = 1'b1;
      end else if (quo < -128'sh80000000) begin
        crd[r] = 32'h80000000;
        p.overflow = 1'b1;
      end else begin
        crd[r] = quo[COORD_W-1:0];
      end
    end
    p.px = crd[0];
    p.py = crd[1];
    p.pz = crd[2];
    return p;
  endfunction

  assign pending = wr_cnt - rd_cnt;

  // store a prediction per input beat, compare each result beat
  always @(posedge clk) begin
    point_t want, got;
    if (rst) begin
      mismatches  <= 0;
      points_seen <= 0;
      misses_seen <= 0;
      clamps_seen <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        exp_mem[wr_cnt % EXP_DEPTH] = solve_point(s_tdata);
        wr_cnt = wr_cnt + 1;
      end
      if (m_tvalid && m_tready) begin
        got = {m_tuser[USER_FOUND], m_tuser[USER_OVF], m_tdata[31:0], m_tdata[63:32],
               m_tdata[95:64]};
        if (wr_cnt == rd_cnt) begin
          if (mismatches < 10) $display("checker: result beat with none expected %h", got);
          mismatches <= mismatches + 1;
        end else begin
          want = exp_mem[rd_cnt % EXP_DEPTH];
          rd_cnt = rd_cnt + 1;
          if (got !== want) begin
            if (mismatches < 10)
              $display("checker: mismatch found %b/%b ovf %b/%b x %h/%h y %h/%h z %h/%h",
                       want.found, got.found, want.overflow, got.overflow,
                       want.px, got.px, want.py, got.py, want.pz, got.pz);
            mismatches <= mismatches + 1;
          end
          if (want.found) points_seen <= points_seen + 1;
          else misses_seen <= misses_seen + 1;
          if (want.overflow) clamps_seen <= clamps_seen + 1;
        end
      end
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// Stimulus and verdict for the three-plane intersection block.
// Needs tpi_pkg, three_plane_intersection and tpi_checker.

module testbench;
  import tpi_pkg::*;

  localparam int LIMIT = 400000;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // a nx, ny, nz, dist; b ...; c ...; pad
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // point_x, point_y, point_z
  logic [OUT_TUSER_W-1:0] m_tuser;        // found, overflow
  int mismatches, pending, points_seen, misses_seen, clamps_seen;
  int cycles = 0;
  int send_idle = 0, recv_stall = 0;
  bit long_hold = 0, hold_started = 0;
  int hold_left = 0;

  logic signed [NORM_W-1:0] nrm [9];
  logic signed [DIST_W-1:0] dst [3];

  always #6 clk = ~clk;

  three_plane_intersection u_top (.*);

  tpi_checker u_chk (.*);

  // timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (long_hold && !hold_started) begin
      hold_started = 1;
      hold_left = 300;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // offer the planes held in nrm/dst until accepted
  task automatic send_planes();
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    for (int r = 0; r < 3; r++) begin
      for (int k = 0; k < 3; k++) d[r*PLANE_W + k*NORM_W +: NORM_W] = nrm[r*3+k];
      d[r*PLANE_W + 3*NORM_W +: DIST_W] = dst[r];
    end
    if ($urandom_range(0, 99) < send_idle) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic set_diag(input logic signed [NORM_W-1:0] a, b, c);
    foreach (nrm[i]) nrm[i] = '0;
    nrm[0] = a;
    nrm[4] = b;
    nrm[8] = c;
  endtask

  task automatic set_dist(input logic signed [DIST_W-1:0] a, b, c);
    dst[0] = a;
    dst[1] = b;
    dst[2] = c;
  endtask

  // random plane triple: full range, near-unit, degenerate or weak
  task automatic rand_planes();
    int kind;
    kind = $urandom_range(0, 9);
    foreach (nrm[i]) nrm[i] = NORM_W'($urandom);
    foreach (dst[i]) dst[i] = DIST_W'($urandom);
    if (kind < 4) begin
      foreach (nrm[i]) nrm[i] = $signed(18'($urandom_range(0, 8191))) - 18'sd4096;
      nrm[0] = nrm[0] + ($urandom_range(0, 1) ? 18'sd65536 : -18'sd65536);
      nrm[4] = nrm[4] + ($urandom_range(0, 1) ? 18'sd65536 : -18'sd65536);
      nrm[8] = nrm[8] + ($urandom_range(0, 1) ? 18'sd65536 : -18'sd65536);
      foreach (dst[i]) dst[i] = $signed(dst[i]) >>> $urandom_range(0, 12);
    end else if (kind < 6) begin
      for (int k = 0; k < 3; k++) nrm[6+k] = nrm[$urandom_range(0, 1)*3 + k];
    end else if (kind < 8) begin
      foreach (nrm[i]) nrm[i] = $signed(nrm[i]) >>> $urandom_range(6, 16);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero matrix, unit axes, extremes, singular and tiny determinants
    set_diag(18'sd0, 18'sd0, 18'sd0);  set_dist(1, -1, 7);               send_planes();
    set_diag(18'sd65536, 18'sd65536, 18'sd65536);
    set_dist(32'h7FFFFFFF, 32'h80000000, 0);                           send_planes();
    set_diag(-18'sd65536, -18'sd65536, -18'sd65536);
    set_dist(32'h80000000, 32'h7FFFFFFF, -1);                          send_planes();
    set_diag(18'sd131071, 18'sd131071, 18'sd131071);
    set_dist(32'h7FFFFFFF, 1, -65536);                                 send_planes();
    set_diag(-18'sd131072, -18'sd131072, -18'sd131072);
    set_dist(32'h80000000, 5, 65536);                                  send_planes();
    set_diag(18'sd1, 18'sd1, 18'sd1);  set_dist(1, -1, 32'h7FFFFFFF);    send_planes();
    set_diag(18'sd1, 18'sd1, 18'sd1);  set_dist(32'h80000000, 0, 0);     send_planes();
    set_diag(-18'sd1, 18'sd1, 18'sd1); set_dist(32'h00008000, 32'hFFFF8000, 1); send_planes();
    foreach (nrm[i]) nrm[i] = 18'sd131071;  set_dist(1, 2, 3);          send_planes();
    foreach (nrm[i]) nrm[i] = -18'sd131072; set_dist(-1, -2, -3);       send_planes();
    foreach (nrm[i]) nrm[i] = '0;
    nrm[1] = 18'sd65536; nrm[3] = 18'sd65536; nrm[8] = 18'sd65536;     // swapped axes
    set_dist(100, -200, 300);                                          send_planes();
    foreach (nrm[i]) nrm[i] = (i % 2) ? 18'sh1FFFF : 18'sh20000;
    set_dist(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);                 send_planes();
    set_diag(18'sd2, -18'sd2, 18'sd65536);
    set_dist(32'h7FFFFFFF, 32'h80000000, 32'h12345678);
    send_planes();

    // random phases with different idling, one long hold-off in the first
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? ((ph == 3) ? 13 : 45) : 0;
      recv_stall = (ph == 2 || ph == 3) ? ((ph == 3) ? 13 : 45) : 0;
      for (int n = 0; n < 250; n++) begin
        if (ph == 0 && n == 20) long_hold = 1;
        rand_planes();
        send_planes();
      end
      s_tvalid <= 1'b0;
      // pause until the pipeline has drained
      while (pending != 0) @(posedge clk);
    end

    repeat (60) @(posedge clk);
    $display("covered %0d found points, %0d singular triples, %0d saturated results",
             points_seen, misses_seen, clamps_seen);
    $display("idle phases: none, sender, receiver, both; one long receiver hold-off");
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
